/* rtl/core/ppr_pkg.sv */
// ppr_pkg: shared types, codes and helpers for the palette pixel run block
// no dependencies
package ppr_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int COORD_BITS    = 9;

  localparam int PAL_AW   = $clog2(PALETTE_DEPTH);
  localparam int COLOR_W  = 24;
  localparam int IDX_W    = 8;
  localparam int CNT_W    = 9;
  localparam int WORD_W   = 16;
  localparam int BYTE_W   = 8;
  localparam int SEQ_W    = 4;

  // opcodes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_DATA  = 2'd2;

  // pixel depth codes
  localparam logic [1:0] MODE_1BPP = 2'd0;
  localparam logic [1:0] MODE_4BPP = 2'd1;
  localparam logic [1:0] MODE_8BPP = 2'd2;
  localparam logic [1:0] MODE_BAD  = 2'd3;

  // controller commands
  localparam logic [BYTE_W-1:0] CMD_COLUMN = 8'h2A;
  localparam logic [BYTE_W-1:0] CMD_PAGE   = 8'h2B;
  localparam logic [BYTE_W-1:0] CMD_WRITE  = 8'h2C;

  // position of each write in the window sequence
  localparam logic [SEQ_W-1:0] WIN_COL_CMD = 4'd0;
  localparam logic [SEQ_W-1:0] WIN_X1_HI   = 4'd1;
  localparam logic [SEQ_W-1:0] WIN_X1_LO   = 4'd2;
  localparam logic [SEQ_W-1:0] WIN_X2_HI   = 4'd3;
  localparam logic [SEQ_W-1:0] WIN_X2_LO   = 4'd4;
  localparam logic [SEQ_W-1:0] WIN_ROW_CMD = 4'd5;
  localparam logic [SEQ_W-1:0] WIN_Y1_HI   = 4'd6;
  localparam logic [SEQ_W-1:0] WIN_Y1_LO   = 4'd7;
  localparam logic [SEQ_W-1:0] WIN_Y2_HI   = 4'd8;
  localparam logic [SEQ_W-1:0] WIN_Y2_LO   = 4'd9;
  localparam logic [SEQ_W-1:0] WIN_WR_CMD  = 4'd10;

  // coordinate mask, all ones once COORD_BITS covers the field
  localparam logic [CNT_W-1:0] COORD_MASK =
    CNT_W'((17'(1) << COORD_BITS) - 17'(1));

  typedef enum logic [1:0] {
    SEL_WIN,
    SEL_HI,
    SEL_LO
  } out_sel_t;

  typedef struct packed {
    logic             pal_write;
    logic             win_load;
    logic             run_load;
    logic             pix_read;
    logic             out_load;
    out_sel_t         out_sel;
    logic [SEQ_W-1:0] win_idx;
  } ppr_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic run_active;
    logic more;
  } ppr_sts_t;

  function automatic logic [WORD_W-1:0] to_rgb565(input logic [COLOR_W-1:0] c);
    return {c[23:19], c[15:10], c[7:3]};
  endfunction

endpackage

/* rtl/core/ppr_ram.sv */
// ppr_ram: generic single write port, single read port ram with registered read
// no dependencies
module ppr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/ppr_ctrl.sv */
// ppr_ctrl: sequencing state machine for window writes and pixel expansion
// depends on ppr_pkg
module ppr_ctrl
  import ppr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_opcode,
  output logic       in_ready,
  input  ppr_sts_t   sts,
  output ppr_cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WIN,
    S_PRD,
    S_PHI,
    S_PLO
  } state_t;

  state_t           state_r, state_nxt;
  logic [SEQ_W-1:0] seq_r, seq_nxt;

  always_comb begin
    state_nxt     = state_r;
    seq_nxt       = seq_r;
    cmd           = '0;
    cmd.out_sel   = SEL_WIN;
    cmd.win_idx   = seq_r;
    in_ready      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_opcode)
            OP_LOAD: cmd.pal_write = 1'b1;
            OP_START: begin
              cmd.win_load = 1'b1;
              seq_nxt      = WIN_COL_CMD;
              state_nxt    = S_WIN;
            end
            OP_DATA: begin
              // idle run or bad depth: byte is dropped
              if (sts.run_active) begin
                cmd.run_load = 1'b1;
                state_nxt    = S_PRD;
              end
            end
            default: ;
          endcase
        end
      end
      S_WIN: begin
        if (sts.slot_free) begin
          cmd.out_load = 1'b1;
          if (seq_r == WIN_WR_CMD) begin
            state_nxt = S_IDLE;
          end else begin
            seq_nxt = seq_r + 1'b1;
          end
        end
      end
      S_PRD: begin
        cmd.pix_read = 1'b1;
        state_nxt    = S_PHI;
      end
      S_PHI: begin
        if (sts.slot_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = SEL_HI;
          state_nxt    = S_PLO;
        end
      end
      S_PLO: begin
        if (sts.slot_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = SEL_LO;
          // next lookup overlaps the low byte
          if (sts.more) begin
            cmd.pix_read = 1'b1;
            state_nxt    = S_PHI;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      seq_r   <= '0;
    end else begin
      state_r <= state_nxt;
      seq_r   <= seq_nxt;
    end
  end

endmodule

/* rtl/core/ppr_dp.sv */
// ppr_dp: run state, window coordinates, palette, pixel select and output register
// depends on ppr_pkg and ppr_ram
module ppr_dp
  import ppr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  ppr_cmd_t           cmd,
  output ppr_sts_t           sts,
  input  logic [8:0]         in_pos_x,
  input  logic [8:0]         in_pos_y,
  input  logic [8:0]         in_pixel_count,
  input  logic [2:0]         in_first_offset,
  input  logic [1:0]         in_depth_mode,
  input  logic [7:0]         in_data_byte,
  input  logic [7:0]         in_entry_index,
  input  logic [23:0]        in_entry_color,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_is_command,
  output logic [7:0]         out_bus_byte,
  output logic               out_last
);

  logic [1:0]          mode_r;
  logic [2:0]          next_off_r;
  logic [CNT_W-1:0]    pl_r;
  logic [BYTE_W-1:0]   byte_r;
  logic [2:0]          off_r;
  logic                more_r;
  logic                oob_r;
  logic [BYTE_W-1:0]   lo_r;
  logic [CNT_W-1:0]    x1_r;
  logic [CNT_W:0]      x2_r;
  logic [CNT_W-1:0]    y1_r;
  logic [CNT_W:0]      y2_r;
  logic                out_valid_r;
  logic                out_cmd_r;
  logic [BYTE_W-1:0]   out_byte_r;
  logic                out_last_r;

  logic [IDX_W-1:0]    pix_idx;
  logic [3:0]          off_end;
  logic [3:0]          off_inc;
  logic [2:0]          start_off;
  logic [COLOR_W-1:0]  rdata;
  logic [COLOR_W-1:0]  color;
  logic [WORD_W-1:0]   rgb;
  logic                wr_ok;
  logic [CNT_W-1:0]    x1_in;
  logic [CNT_W-1:0]    y1_in;
  logic [WORD_W-1:0]   x1_w, x2_w, y1_w, y2_w;
  logic                sel_cmd;
  logic [BYTE_W-1:0]   sel_byte;
  logic                sel_last;

  // pixel index at the current position of the held byte
  always_comb begin
    unique case (mode_r)
      MODE_1BPP: pix_idx = IDX_W'((byte_r >> (3'd7 - off_r)) & 8'd1);
      MODE_4BPP: pix_idx = (off_r == 3'd0) ? {4'd0, byte_r[7:4]} : {4'd0, byte_r[3:0]};
      default:   pix_idx = byte_r;
    endcase
  end

  always_comb begin
    unique case (mode_r)
      MODE_1BPP: off_end = 4'd8;
      MODE_4BPP: off_end = 4'd2;
      default:   off_end = 4'd1;
    endcase
  end

  always_comb begin
    unique case (mode_r)
      MODE_1BPP: start_off = next_off_r;
      MODE_4BPP: start_off = {2'd0, next_off_r[0]};
      default:   start_off = 3'd0;
    endcase
  end

  assign off_inc = {1'b0, off_r} + 4'd1;
  assign wr_ok   = {1'b0, in_entry_index} < (IDX_W+1)'(PALETTE_DEPTH);

  ppr_ram #(
    .WIDTH(COLOR_W),
    .DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk  (clk),
    .we   (cmd.pal_write && wr_ok),
    .waddr(in_entry_index[PAL_AW-1:0]),
    .wdata(in_entry_color),
    .re   (cmd.pix_read),
    .raddr(pix_idx[PAL_AW-1:0]),
    .rdata(rdata)
  );

  // index past the palette reads as black
  assign color = oob_r ? '0 : rdata;
  assign rgb   = to_rgb565(color);

  assign x1_in = in_pos_x & COORD_MASK;
  assign y1_in = in_pos_y & COORD_MASK;
  assign x1_w  = WORD_W'(x1_r);
  assign x2_w  = WORD_W'(x2_r);
  assign y1_w  = WORD_W'(y1_r);
  assign y2_w  = WORD_W'(y2_r);

  always_comb begin
    sel_cmd  = 1'b0;
    sel_last = 1'b0;
    sel_byte = '0;
    unique case (cmd.out_sel)
      SEL_WIN: begin
        unique case (cmd.win_idx)
          WIN_COL_CMD: begin sel_cmd = 1'b1; sel_byte = CMD_COLUMN; end
          WIN_X1_HI:   sel_byte = x1_w[15:8];
          WIN_X1_LO:   sel_byte = x1_w[7:0];
          WIN_X2_HI:   sel_byte = x2_w[15:8];
          WIN_X2_LO:   sel_byte = x2_w[7:0];
          WIN_ROW_CMD: begin sel_cmd = 1'b1; sel_byte = CMD_PAGE; end
          WIN_Y1_HI:   sel_byte = y1_w[15:8];
          WIN_Y1_LO:   sel_byte = y1_w[7:0];
          WIN_Y2_HI:   sel_byte = y2_w[15:8];
          WIN_Y2_LO:   sel_byte = y2_w[7:0];
          WIN_WR_CMD: begin
            sel_cmd  = 1'b1;
            sel_byte = CMD_WRITE;
            sel_last = 1'b1;
          end
          default: ;
        endcase
      end
      SEL_HI: sel_byte = rgb[15:8];
      SEL_LO: begin
        sel_byte = lo_r;
        sel_last = !more_r;
      end
      default: ;
    endcase
  end

  // run state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_1BPP;
      next_off_r <= '0;
      pl_r       <= '0;
    end else begin
      if (cmd.win_load) begin
        mode_r     <= in_depth_mode;
        next_off_r <= in_first_offset;
        pl_r       <= in_pixel_count;
      end else begin
        if (cmd.run_load) begin
          next_off_r <= '0;
        end
        if (cmd.pix_read) begin
          pl_r <= pl_r - 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.win_load) begin
      x1_r <= x1_in;
      x2_r <= {1'b0, x1_in} + {1'b0, in_pixel_count};
      y1_r <= y1_in;
      y2_r <= {1'b0, y1_in} + (CNT_W+1)'(1);
    end
    if (cmd.run_load) begin
      byte_r <= in_data_byte;
      off_r  <= start_off;
    end
    if (cmd.pix_read) begin
      off_r  <= off_inc[2:0];
      more_r <= (pl_r != CNT_W'(1)) && (off_inc < off_end);
      oob_r  <= {1'b0, pix_idx} >= (IDX_W+1)'(PALETTE_DEPTH);
    end
    if (cmd.out_load && cmd.out_sel == SEL_HI) begin
      lo_r <= rgb[7:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_cmd_r  <= sel_cmd;
      out_byte_r <= sel_byte;
      out_last_r <= sel_last;
    end
  end

  assign sts.slot_free  = !out_valid_r || out_ready;
  assign sts.run_active = (pl_r != '0) && (mode_r != MODE_BAD);
  assign sts.more       = more_r;

  assign out_valid      = out_valid_r;
  assign out_is_command = out_cmd_r;
  assign out_bus_byte   = out_byte_r;
  assign out_last       = out_last_r;

endmodule

/* rtl/core/palette_pixel_run_to_lcd_bus.sv */
// palette_pixel_run_to_lcd_bus: top level, palettized pixel runs to display bus writes
// depends on ppr_pkg, ppr_ctrl, ppr_dp (which holds the ppr_ram palette)
//
//   channel  | handshake           | payload
//   in_      | in_valid/in_ready   | opcode, pos_x, pos_y, pixel_count, first_offset,
//            |                     | depth_mode, data_byte, entry_index, entry_color
//   out_     | out_valid/out_ready | is_command, bus_byte, last
//
// palette load: written into the palette when taken, no result
// start run: eleven bus writes, one per cycle while the output is not stalled; the input
//   is taken again after the last
// data byte: accepted, then one palette read, then a high and a low byte per pixel; the
//   next lookup overlaps the low byte, the pace being set by the single palette read port
//   and the one output register
// a stalled output holds the sequence; the palette needs no clearing after reset
module palette_pixel_run_to_lcd_bus
  import ppr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [8:0]  in_pos_x,
  input  logic [8:0]  in_pos_y,
  input  logic [8:0]  in_pixel_count,
  input  logic [2:0]  in_first_offset,
  input  logic [1:0]  in_depth_mode,
  input  logic [7:0]  in_data_byte,
  input  logic [7:0]  in_entry_index,
  input  logic [23:0] in_entry_color,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_is_command,
  output logic [7:0]  out_bus_byte,
  output logic        out_last
);

  ppr_cmd_t cmd;
  ppr_sts_t sts;

  ppr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_opcode(in_opcode),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ppr_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_pixel_count (in_pixel_count),
    .in_first_offset(in_first_offset),
    .in_depth_mode  (in_depth_mode),
    .in_data_byte   (in_data_byte),
    .in_entry_index (in_entry_index),
    .in_entry_color (in_entry_color),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_is_command (out_is_command),
    .out_bus_byte   (out_bus_byte),
    .out_last       (out_last)
  );

  // nothing is emitted or looked up while a new item can be taken
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (!cmd.out_load && !cmd.pix_read))
    else $error("output or lookup while ready for input");

  // a command item closing a sequence is always the memory write command
  a_last_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last && out_is_command) |-> (out_bus_byte == CMD_WRITE))
    else $error("final command is not the write command");

  // the output register is never overwritten while an item waits
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !cmd.out_load)
    else $error("output register overwritten while stalled");

endmodule

/* tb/sv/tb_top.sv */
// tb_top: self-checking testbench for palette_pixel_run_to_lcd_bus
// depends on ppr_pkg and the rtl top level; predicts every bus write and compares
// directed palette, window and depth cases, then random traffic with and then without back pressure
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ppr_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int HOLD_CYCLES    = 120;
  localparam int WATCHDOG_LIMIT = 1500;
  localparam int TAIL_CYCLES    = 40;
  localparam int PAL_USED       = 16;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [8:0]  pos_x;
    logic [8:0]  pos_y;
    logic [8:0]  pixel_count;
    logic [2:0]  first_offset;
    logic [1:0]  depth_mode;
    logic [7:0]  data_byte;
    logic [7:0]  entry_index;
    logic [23:0] entry_color;
  } pix_item_t;

  typedef struct packed {
    logic       is_command;
    logic [7:0] bus_byte;
    logic       last;
  } bus_write_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_opcode;
  logic [8:0]  in_pos_x;
  logic [8:0]  in_pos_y;
  logic [8:0]  in_pixel_count;
  logic [2:0]  in_first_offset;
  logic [1:0]  in_depth_mode;
  logic [7:0]  in_data_byte;
  logic [7:0]  in_entry_index;
  logic [23:0] in_entry_color;
  logic        out_valid;
  logic        out_ready;
  logic        out_is_command;
  logic [7:0]  out_bus_byte;
  logic        out_last;

  // shadow of the block state
  logic [23:0] pal_shadow [256];
  logic [8:0]  run_left;
  logic [2:0]  run_pos;
  logic [1:0]  run_depth;

  bus_write_t  bus_q [$];

  bit idle_on;
  bit hold_req;
  int mismatches;
  int items_sent;
  int writes_checked;
  int runs_by_mode [4];
  int quiet_cycles;

  palette_pixel_run_to_lcd_bus dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_pixel_count  (in_pixel_count),
    .in_first_offset (in_first_offset),
    .in_depth_mode   (in_depth_mode),
    .in_data_byte    (in_data_byte),
    .in_entry_index  (in_entry_index),
    .in_entry_color  (in_entry_color),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_is_command  (out_is_command),
    .out_bus_byte    (out_bus_byte),
    .out_last        (out_last)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // ---------------------------------------------------------------- prediction

  function automatic void push_bus(input logic cmd, input logic [7:0] b);
    bus_write_t w;
    w.is_command = cmd;
    w.bus_byte   = b;
    w.last       = 1'b0;
    bus_q.push_back(w);
  endfunction

  function automatic void push_word(input logic [15:0] word);
    push_bus(1'b0, word[15:8]);
    push_bus(1'b0, word[7:0]);
  endfunction

  function automatic void push_pixel(input logic [7:0] idx);
    logic [23:0] c;
    logic [15:0] rgb;
    c   = pal_shadow[idx];
    rgb = (16'(c >> 8) & 16'hF800) | (16'(c >> 5) & 16'h07E0) | (16'(c >> 3) & 16'h001F);
    push_word(rgb);
  endfunction

  function automatic void predict_item(input pix_item_t it);
    int          first;
    int          pos;
    logic [15:0] x_lo;
    logic [15:0] x_hi;
    logic [15:0] y_lo;
    logic [15:0] y_hi;
    logic [15:0] swap;
    bus_write_t  w;
    first = bus_q.size();
    case (it.opcode)
      OP_LOAD: begin
        pal_shadow[it.entry_index] = it.entry_color;
      end
      OP_START: begin
        x_lo = 16'(it.pos_x & COORD_MASK);
        y_lo = 16'(it.pos_y & COORD_MASK);
        x_hi = x_lo + 16'(it.pixel_count);
        y_hi = y_lo + 16'd1;
        if (x_lo > x_hi) begin
          swap = x_lo; x_lo = x_hi; x_hi = swap;
        end
        if (y_lo > y_hi) begin
          swap = y_lo; y_lo = y_hi; y_hi = swap;
        end
        push_bus(1'b1, CMD_COLUMN);
        push_word(x_lo);
        push_word(x_hi);
        push_bus(1'b1, CMD_PAGE);
        push_word(y_lo);
        push_word(y_hi);
        push_bus(1'b1, CMD_WRITE);
        run_left  = it.pixel_count;
        run_pos   = it.first_offset;
        run_depth = it.depth_mode;
        runs_by_mode[it.depth_mode]++;
      end
      OP_DATA: begin
        // no pixels pending or bad depth: byte is dropped, state untouched
        if (run_left != 0 && run_depth != MODE_BAD) begin
          case (run_depth)
            MODE_1BPP: begin
              for (pos = run_pos; pos < 8 && run_left != 0; pos++) begin
                push_pixel({7'd0, it.data_byte[7 - pos]});
                run_left--;
              end
            end
            MODE_4BPP: begin
              // only the low offset bit selects the nibble
              for (pos = run_pos[0]; pos < 2 && run_left != 0; pos++) begin
                push_pixel(pos == 0 ? {4'd0, it.data_byte[7:4]} : {4'd0, it.data_byte[3:0]});
                run_left--;
              end
            end
            default: begin
              push_pixel(it.data_byte);
              run_left--;
            end
          endcase
          run_pos = 3'd0;
        end
      end
      default: ;
    endcase
    if (bus_q.size() > first) begin
      w = bus_q.pop_back();
      w.last = 1'b1;
      bus_q.push_back(w);
    end
  endfunction

  // ---------------------------------------------------------------- result checking

  always @(posedge clk) begin : bus_check
    bus_write_t want;
    if (rst_n && out_valid && out_ready) begin
      writes_checked++;
      if (bus_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected bus write: cmd=%0b byte=%02h last=%0b",
                   $realtime, out_is_command, out_bus_byte, out_last);
      end else begin
        want = bus_q.pop_front();
        if (want.is_command !== out_is_command || want.bus_byte !== out_bus_byte ||
            want.last !== out_last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"[%0t] bus write %0d: expected cmd=%0b byte=%02h last=%0b, ",
                      "got cmd=%0b byte=%02h last=%0b"},
                     $realtime, writes_checked, want.is_command, want.bus_byte, want.last,
                     out_is_command, out_bus_byte, out_last);
        end
      end
    end
  end

  // ---------------------------------------------------------------- result side stalls

  initial begin : bus_sink
    out_ready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  // in an eight-bit run the byte is the palette index, kept inside the loaded entries
  function automatic pix_item_t random_item(input logic [1:0] op);
    pix_item_t it;
    it.opcode       = op;
    it.pos_x        = 9'($urandom_range(0, 511));
    it.pos_y        = 9'($urandom_range(0, 511));
    it.pixel_count  = 9'($urandom_range(0, 511));
    it.first_offset = 3'($urandom_range(0, 7));
    it.depth_mode   = 2'($urandom_range(0, 3));
    it.data_byte    = (run_depth == MODE_8BPP) ? 8'($urandom_range(0, PAL_USED - 1))
                                               : 8'($urandom_range(0, 255));
    it.entry_index  = 8'($urandom_range(0, 255));
    it.entry_color  = 24'($urandom_range(0, 24'hFFFFFF));
    return it;
  endfunction

  function automatic pix_item_t start_item(input logic [8:0] x, input logic [8:0] y,
                                           input logic [8:0] cnt, input logic [2:0] off,
                                           input logic [1:0] mode);
    pix_item_t it;
    it = random_item(OP_START);
    it.pos_x        = x;
    it.pos_y        = y;
    it.pixel_count  = cnt;
    it.first_offset = off;
    it.depth_mode   = mode;
    return it;
  endfunction

  function automatic pix_item_t data_item(input logic [7:0] b);
    pix_item_t it;
    it = random_item(OP_DATA);
    it.data_byte = b;
    return it;
  endfunction

  task automatic send_item(input pix_item_t it);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_opcode       <= it.opcode;
    in_pos_x        <= it.pos_x;
    in_pos_y        <= it.pos_y;
    in_pixel_count  <= it.pixel_count;
    in_first_offset <= it.first_offset;
    in_depth_mode   <= it.depth_mode;
    in_data_byte    <= it.data_byte;
    in_entry_index  <= it.entry_index;
    in_entry_color  <= it.entry_color;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_item(it);
    items_sent++;
  endtask

  // sender pauses until every predicted bus write has come out
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (bus_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // pixel indices stay below PAL_USED, so every entry looked up has been written
  task automatic load_palette();
    pix_item_t it;
    int i;
    for (i = 0; i < PAL_USED; i++) begin
      it = random_item(OP_LOAD);
      it.entry_index = 8'(i);
      if (i == 0) it.entry_color = 24'h000000;
      if (i == 1 || i == PAL_USED - 1) it.entry_color = 24'hFFFFFF;
      send_item(it);
    end
    wait_drain();
  endtask

  task automatic test_stray_items();
    send_item(data_item(8'hFF));       // no run yet
    send_item(random_item(OP_UNUSED));
    wait_drain();
  endtask

  task automatic test_window_edges();
    // zero-length run: window only, data byte dropped
    send_item(start_item(9'd0, 9'd0, 9'd0, 3'd0, MODE_1BPP));
    send_item(data_item(8'hA5));
    // largest coordinates with the unused depth code
    send_item(start_item(9'd511, 9'd511, 9'd511, 3'd7, MODE_BAD));
    send_item(data_item(8'h5A));
    wait_drain();
  endtask

  task automatic test_one_bit_run();
    send_item(start_item(9'd17, 9'd300, 9'd10, 3'd5, MODE_1BPP));
    send_item(data_item(8'hA5));
    send_item(data_item(8'h3C));
    send_item(data_item(8'hFF));       // run already done
    wait_drain();
  endtask

  task automatic test_four_bit_run();
    // odd offset begins at the low nibble
    send_item(start_item(9'd256, 9'd1, 9'd3, 3'd7, MODE_4BPP));
    send_item(data_item(8'h3C));
    send_item(data_item(8'hF0));
    wait_drain();
  endtask

  task automatic test_eight_bit_run();
    send_item(start_item(9'd100, 9'd200, 9'd2, 3'd6, MODE_8BPP));
    send_item(data_item(8'h00));
    send_item(data_item(8'(PAL_USED - 1)));
    wait_drain();
  endtask

  task automatic test_back_pressure();
    int i;
    hold_req = 1'b1;
    send_item(start_item(9'd3, 9'd4, 9'd64, 3'd0, MODE_1BPP));
    for (i = 0; i < 8; i++)
      send_item(data_item(8'($urandom_range(0, 255))));
    wait_drain();
  endtask

  function automatic int bytes_needed(input pix_item_t it);
    int cnt;
    cnt = it.pixel_count;
    case (it.depth_mode)
      MODE_1BPP: return (it.first_offset + cnt + 7) / 8;
      MODE_4BPP: return (it.first_offset[0] + cnt + 1) / 2;
      MODE_8BPP: return cnt;
      default:   return 2;
    endcase
  endfunction

  // mostly well-formed runs with random content, some loads and stray items
  task automatic test_random_traffic(input int budget);
    pix_item_t it;
    int roll;
    int nbytes;
    int k;
    while (budget > 0) begin
      roll = $urandom_range(0, 9);
      if (roll < 7) begin
        it = random_item(OP_START);
        it.depth_mode = ($urandom_range(0, 9) == 0) ? MODE_BAD : 2'($urandom_range(0, 2));
        if ($urandom_range(0, 3) != 0)
          it.pixel_count = 9'($urandom_range(0, 24));
        nbytes = bytes_needed(it);
        if (nbytes > 6) nbytes = $urandom_range(1, 6);
        if ($urandom_range(0, 3) == 0) nbytes++;
        send_item(it);
        budget--;
        for (k = 0; k < nbytes; k++) begin
          send_item(random_item(OP_DATA));
          budget--;
        end
      end else if (roll == 7) begin
        send_item(random_item(OP_LOAD));
        budget--;
      end else if (roll == 8) begin
        send_item(random_item(OP_DATA));
        budget--;
      end else begin
        send_item(random_item(OP_UNUSED));
        budget--;
      end
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_opcode       = OP_LOAD;
    in_pos_x        = '0;
    in_pos_y        = '0;
    in_pixel_count  = '0;
    in_first_offset = '0;
    in_depth_mode   = MODE_1BPP;
    in_data_byte    = '0;
    in_entry_index  = '0;
    in_entry_color  = '0;
    idle_on         = 1'b1;
    hold_req        = 1'b0;
    mismatches      = 0;
    items_sent      = 0;
    writes_checked  = 0;
    quiet_cycles    = 0;
    run_left        = '0;
    run_pos         = '0;
    run_depth       = MODE_1BPP;
    runs_by_mode    = '{default: 0};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_palette();
    test_stray_items();
    test_window_edges();
    test_one_bit_run();
    test_four_bit_run();
    test_eight_bit_run();
    test_back_pressure();
    test_random_traffic(180);
    wait_drain();
    idle_on = 1'b0;
    test_random_traffic(40);

    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("run covered %0d input items and %0d bus writes", items_sent, writes_checked);
    $display("runs started per depth 1/4/8/unused: %0d/%0d/%0d/%0d, mismatches: %0d",
             runs_by_mode[0], runs_by_mode[1], runs_by_mode[2], runs_by_mode[3], mismatches);
    if (mismatches == 0 && bus_q.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/ppr_pkg.sv
rtl/core/ppr_ram.sv
rtl/core/ppr_ctrl.sv
rtl/core/ppr_dp.sv
rtl/core/palette_pixel_run_to_lcd_bus.sv
tb/sv/tb_top.sv
